>>> hdl/spfs_pkg.sv
package spfs_pkg;

   localparam int TABLE_SIZE = 65536;
   localparam int VAL_W      = $clog2(TABLE_SIZE);
   localparam int LIM_W      = VAL_W + 1;
   localparam int EXP_W      = 5;
   localparam int SQ_W       = 2 * VAL_W;
   localparam int DIV_CNT_W  = $clog2(VAL_W + 1);

   localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(TABLE_SIZE);

   typedef enum logic [1:0] {
      ACT_BUILD  = 2'd0,
      ACT_TEST   = 2'd1,
      ACT_FACTOR = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_EMPTY   = 2'd1,
      STAT_RANGE   = 2'd2,
      STAT_UNBUILT = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SEL_PLAIN  = 2'd0,
      SEL_PRIME  = 2'd1,
      SEL_FACTOR = 2'd2
   } rsp_sel_type;

   typedef struct packed {
      logic        capture;
      logic        init_start;
      logic        init_write;
      logic        sv_start;
      logic        sq_load;
      logic        rd_i;
      logic        i_inc;
      logic        rd_j;
      logic        mark;
      logic        j_step;
      logic        rd_n;
      logic        div_start;
      logic        div_take;
      logic        ex_clear;
      logic        rsp_emit;
      rsp_sel_type rsp_sel;
      status_type  rsp_status;
      logic        rsp_last;
   } spfs_cmd_type;

   typedef struct packed {
      action_type action;
      logic       j_ge_lim;
      logic       sq_ge_lim;
      logic       rd_eq_i;
      logic       rd_eq_j;
      logic       rd_eq_p;
      logic       val_ge_lim;
      logic       val_lt2;
      logic       val_zero;
      logic       val_one;
      logic       ex_zero;
      logic       div_done;
   } spfs_sts_type;

endpackage

>>> hdl/spfs_div.sv
module spfs_div import spfs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [VAL_W-1:0] dividend,
   input  logic [VAL_W-1:0] divisor,
   output logic             done,
   output logic [VAL_W-1:0] quotient
);

   logic [VAL_W-1:0]     quo_ff, quo_in;
   logic [VAL_W-1:0]     rem_ff, rem_in;
   logic [VAL_W-1:0]     dsr_ff, dsr_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [VAL_W:0]       trial;
   logic [VAL_W:0]       diff;
   logic                 fits;

   // one quotient bit a cycle, restoring
   always_comb begin
      trial  = {rem_ff, quo_ff[VAL_W-1]};
      diff   = trial - {1'b0, dsr_ff};
      fits   = trial >= {1'b0, dsr_ff};
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = DIV_CNT_W'(VAL_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         quo_in  = {quo_ff[VAL_W-2:0], fits};
         rem_in  = fits ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         run_in  = cnt_ff != DIV_CNT_W'(1);
         done_in = cnt_ff == DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> hdl/spfs_dp.sv
module spfs_dp import spfs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  spfs_cmd_type     cmd,
   output spfs_sts_type     sts,
   input  logic [1:0]       req_action,
   input  logic [VAL_W-1:0] req_value,
   input  logic             csr_write,
   input  logic [LIM_W-1:0] csr_limit,
   output logic             rsp_strobe,
   output logic             rsp_prime_flag,
   output logic [VAL_W-1:0] rsp_factor,
   output logic [EXP_W-1:0] rsp_exponent,
   output logic [1:0]       rsp_status,
   output logic             rsp_last
);

   logic [VAL_W-1:0] factor_table_mem [TABLE_SIZE];

   logic [LIM_W-1:0] limit_ff;
   logic [LIM_W-1:0] lim;
   action_type       action_ff;
   logic [VAL_W-1:0] n_ff;
   logic [VAL_W-1:0] p_ff;
   logic [EXP_W-1:0] ex_ff;
   logic [VAL_W-1:0] i_ff;
   logic [LIM_W-1:0] j_ff;
   logic [SQ_W-1:0]  sq_ff;
   logic [VAL_W-1:0] rd_ff;

   logic             rd_en;
   logic [VAL_W-1:0] rd_addr;
   logic             wr_en;
   logic [VAL_W-1:0] wr_addr;
   logic [VAL_W-1:0] wr_data;

   logic             div_done;
   logic [VAL_W-1:0] div_quo;

   logic             valid_ff;
   logic             pf_ff;
   logic [VAL_W-1:0] factor_ff;
   logic [EXP_W-1:0] exp_ff;
   status_type       status_ff;
   logic             last_ff;

   assign lim = (limit_ff > LIMIT_RESET) ? LIMIT_RESET : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_write) begin
         limit_ff <= csr_limit;
      end
   end

   // table port selection
   always_comb begin
      rd_en   = cmd.rd_i | cmd.rd_j | cmd.rd_n;
      rd_addr = n_ff;
      if (cmd.rd_i) begin
         rd_addr = i_ff;
      end else if (cmd.rd_j) begin
         rd_addr = j_ff[VAL_W-1:0];
      end
      wr_en   = cmd.init_write | cmd.mark;
      wr_addr = j_ff[VAL_W-1:0];
      wr_data = cmd.mark ? i_ff : j_ff[VAL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         factor_table_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= factor_table_mem[rd_addr];
      end
   end

   // sieve counters and factorising registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= action_type'(req_action);
         n_ff      <= req_value;
         ex_ff     <= '0;
      end else begin
         if (cmd.div_take) begin
            n_ff  <= div_quo;
            ex_ff <= ex_ff + 1'b1;
         end else if (cmd.ex_clear) begin
            ex_ff <= '0;
         end
      end
      if (cmd.div_start) begin
         p_ff <= rd_ff;
      end
      if (cmd.sv_start) begin
         i_ff <= VAL_W'(2);
      end else if (cmd.i_inc) begin
         i_ff <= i_ff + 1'b1;
      end
      if (cmd.sq_load) begin
         sq_ff <= SQ_W'(i_ff) * SQ_W'(i_ff);
      end
      if (cmd.init_start) begin
         j_ff <= '0;
      end else if (cmd.init_write) begin
         j_ff <= j_ff + 1'b1;
      end else if (cmd.rd_i) begin
         j_ff <= sq_ff[LIM_W-1:0];
      end else if (cmd.j_step) begin
         j_ff <= j_ff + {1'b0, i_ff};
      end
   end

   spfs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (n_ff),
      .divisor  (rd_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      sts.action     = action_ff;
      sts.j_ge_lim   = j_ff >= lim;
      sts.sq_ge_lim  = sq_ff >= SQ_W'(lim);
      sts.rd_eq_i    = rd_ff == i_ff;
      sts.rd_eq_j    = rd_ff == j_ff[VAL_W-1:0];
      sts.rd_eq_p    = rd_ff == p_ff;
      sts.val_ge_lim = {1'b0, n_ff} >= lim;
      sts.val_lt2    = n_ff < VAL_W'(2);
      sts.val_zero   = n_ff == '0;
      sts.val_one    = n_ff == VAL_W'(1);
      sts.ex_zero    = ex_ff == '0;
      sts.div_done   = div_done;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.rsp_emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_emit) begin
         pf_ff     <= 1'b0;
         factor_ff <= '0;
         exp_ff    <= '0;
         status_ff <= cmd.rsp_status;
         last_ff   <= 1'b1;
         unique case (cmd.rsp_sel)
            SEL_PRIME: begin
               pf_ff <= rd_ff == n_ff;
            end
            SEL_FACTOR: begin
               factor_ff <= p_ff;
               exp_ff    <= ex_ff;
               last_ff   <= cmd.rsp_last;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_strobe     = valid_ff;
   assign rsp_prime_flag = pf_ff;
   assign rsp_factor     = factor_ff;
   assign rsp_exponent   = exp_ff;
   assign rsp_status     = status_ff;
   assign rsp_last       = last_ff;

   a_mark_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.mark |-> ({1'b0, i_ff} < j_ff) && (j_ff < lim))
      else $error("sieve marks an entry outside the active range");

   a_mid_result_is_factor: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !last_ff |-> (status_ff == STAT_OK) && (factor_ff >= VAL_W'(2))
                               && (exp_ff != '0))
      else $error("non-final result without a valid prime power");

   a_error_fields_clear: assert property (@(posedge clock) disable iff (reset)
      valid_ff && (status_ff != STAT_OK) |-> !pf_ff && (factor_ff == '0) && (exp_ff == '0))
      else $error("error result carries payload");

endmodule

>>> hdl/spfs_ctrl.sv
module spfs_ctrl import spfs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         csr_write,
   input  spfs_sts_type sts,
   output spfs_cmd_type cmd,
   output logic         busy
);

   typedef enum logic [12:0] {
      ST_IDLE    = 13'b0_0000_0000_0001,
      ST_DECODE  = 13'b0_0000_0000_0010,
      ST_INIT    = 13'b0_0000_0000_0100,
      ST_SV_SQ   = 13'b0_0000_0000_1000,
      ST_SV_READ = 13'b0_0000_0001_0000,
      ST_SV_TEST = 13'b0_0000_0010_0000,
      ST_MK_READ = 13'b0_0000_0100_0000,
      ST_MK_TEST = 13'b0_0000_1000_0000,
      ST_Q_READ  = 13'b0_0001_0000_0000,
      ST_F_READ  = 13'b0_0010_0000_0000,
      ST_F_CHECK = 13'b0_0100_0000_0000,
      ST_F_DIV   = 13'b0_1000_0000_0000,
      ST_Q_TEST  = 13'b1_0000_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_IDLE;
            if (sts.action == ACT_BUILD) begin
               cmd.init_start = 1'b1;
               state_in       = ST_INIT;
            end else if (sts.action != ACT_NONE) begin
               priority if (!ready_ff) begin
                  cmd.rsp_emit   = 1'b1;
                  cmd.rsp_status = STAT_UNBUILT;
               end else if (sts.val_ge_lim) begin
                  cmd.rsp_emit   = 1'b1;
                  cmd.rsp_status = STAT_RANGE;
               end else if (sts.action == ACT_TEST) begin
                  if (sts.val_lt2) begin
                     cmd.rsp_emit = 1'b1;
                  end else begin
                     state_in = ST_Q_READ;
                  end
               end else if (sts.val_zero) begin
                  cmd.rsp_emit   = 1'b1;
                  cmd.rsp_status = STAT_RANGE;
               end else if (sts.val_one) begin
                  cmd.rsp_emit   = 1'b1;
                  cmd.rsp_status = STAT_EMPTY;
               end else begin
                  state_in = ST_F_READ;
               end
            end
         end
         ST_INIT: begin
            if (sts.j_ge_lim) begin
               cmd.sv_start = 1'b1;
               state_in     = ST_SV_SQ;
            end else begin
               cmd.init_write = 1'b1;
            end
         end
         ST_SV_SQ: begin
            cmd.sq_load = 1'b1;
            state_in    = ST_SV_READ;
         end
         ST_SV_READ: begin
            if (sts.sq_ge_lim) begin
               cmd.rsp_emit = 1'b1;
               ready_in     = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cmd.rd_i = 1'b1;
               state_in = ST_SV_TEST;
            end
         end
         ST_SV_TEST: begin
            if (sts.rd_eq_i) begin
               state_in = ST_MK_READ;
            end else begin
               cmd.i_inc = 1'b1;
               state_in  = ST_SV_SQ;
            end
         end
         ST_MK_READ: begin
            if (sts.j_ge_lim) begin
               cmd.i_inc = 1'b1;
               state_in  = ST_SV_SQ;
            end else begin
               cmd.rd_j = 1'b1;
               state_in = ST_MK_TEST;
            end
         end
         ST_MK_TEST: begin
            cmd.mark   = sts.rd_eq_j;
            cmd.j_step = 1'b1;
            state_in   = ST_MK_READ;
         end
         ST_Q_READ: begin
            cmd.rd_n = 1'b1;
            state_in = ST_Q_TEST;
         end
         ST_Q_TEST: begin
            cmd.rsp_emit = 1'b1;
            cmd.rsp_sel  = SEL_PRIME;
            state_in     = ST_IDLE;
         end
         ST_F_READ: begin
            cmd.rd_n = 1'b1;
            state_in = ST_F_CHECK;
         end
         ST_F_CHECK: begin
            priority if (sts.val_one) begin
               cmd.rsp_emit = 1'b1;
               cmd.rsp_sel  = SEL_FACTOR;
               cmd.rsp_last = 1'b1;
               state_in     = ST_IDLE;
            end else if (!sts.ex_zero && !sts.rd_eq_p) begin
               cmd.rsp_emit = 1'b1;
               cmd.rsp_sel  = SEL_FACTOR;
               cmd.ex_clear = 1'b1;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_F_DIV;
            end
         end
         ST_F_DIV: begin
            if (sts.div_done) begin
               cmd.div_take = 1'b1;
               state_in     = ST_F_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_write) begin
         ready_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign busy = state_ff != ST_IDLE;

   a_limit_write_drops_table: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> !ready_ff)
      else $error("table still marked ready after a limit write");

   a_factor_has_power: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_emit && (cmd.rsp_sel == SEL_FACTOR) |-> !sts.ex_zero)
      else $error("factor result with zero exponent");

   a_emit_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_emit |-> busy && !cmd.capture)
      else $error("result issued while idle");

endmodule

>>> hdl/smallest_prime_factor_sieve.sv
// Smallest-prime-factor sieve. Pulse start while busy is low to transfer one
// command (req_action, req_value); results come back on the rsp_ ports, each
// held for exactly one cycle under rsp_strobe, and the receiver cannot stall
// them, so capture every strobed cycle. rsp_last marks the final result of a
// command. Build (action 0) walks the table once to seed each entry with its
// own index, then runs the sieve over one memory port. A prime test flags
// the value prime when its table entry equals the value. Factorise divides
// each prime out with the bit-serial divider and gives one result per
// distinct prime factor, with its exponent. Queries before a build, or
// after any limit write, answer with a "not built" status. The limit register
// is written through csr_valid/csr_ready/csr_limit and must only be written
// while busy is low and no result is outstanding.
module smallest_prime_factor_sieve import spfs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   // command channel
   input  logic             start,
   output logic             busy,
   input  logic [1:0]       req_action,
   input  logic [VAL_W-1:0] req_value,
   // result channel
   output logic             rsp_strobe,
   output logic             rsp_prime_flag,
   output logic [VAL_W-1:0] rsp_factor,
   output logic [EXP_W-1:0] rsp_exponent,
   output logic [1:0]       rsp_status,
   output logic             rsp_last,
   // limit register write channel
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [LIM_W-1:0] csr_limit
);

   spfs_cmd_type cmd;
   spfs_sts_type sts;
   logic         csr_write;

   // Writes are always taken; the controller drops the built flag on each.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   // Sequencer: decodes the command, steps the sieve loops and the
   // factorising loop, and issues the result strobes.
   spfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .csr_write (csr_write),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy)
   );

   // Datapath: factor table memory, sieve counters, divider and the
   // result register.
   spfs_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_action     (req_action),
      .req_value      (req_value),
      .csr_write      (csr_write),
      .csr_limit      (csr_limit),
      .rsp_strobe     (rsp_strobe),
      .rsp_prime_flag (rsp_prime_flag),
      .rsp_factor     (rsp_factor),
      .rsp_exponent   (rsp_exponent),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

endmodule
